@@ rtl/core/lcp_pkg.sv @@
// Shared widths, pipeline depths, status codes and payload types of the touch point block.
package lcp_pkg;

    // Fixed-point format and field widths
    localparam int FRAC_BITS = 16;
    localparam int CW        = 32;              // coordinate width
    localparam int RW        = 31;              // radius width

    // Pipelined multiplier: signed MW x MW, split into NCH chunks of CH bits
    localparam int MW        = 66;
    localparam int PW        = 2 * MW;
    localparam int NCH       = 3;
    localparam int CH        = MW / NCH;
    localparam int LAT_MUL   = 5;

    // Square root: EW-bit radicand, one root bit per stage
    localparam int EW        = 126;
    localparam int RTW       = EW / 2;
    localparam int SQREMW    = RTW + 2;
    localparam int LAT_SQRT  = RTW;

    // Divider: NW-bit signed numerator, DW-bit divisor, QB quotient bits
    localparam int NW        = 100;
    localparam int DW        = 64;
    localparam int QB        = 41;
    localparam int QW        = QB + 1;
    localparam int LAT_DIV   = QB + 4;

    // Squared distance width
    localparam int DISTW     = 2 * (CW + 1) + 2;

    // Valid line depth from the input register to the last stage
    localparam int LAT_TOTAL = 1 + (LAT_MUL + 1) + (LAT_MUL + 1) + LAT_SQRT
                             + (LAT_MUL + 1) + (LAT_DIV + 1) + (LAT_MUL + 1);

    // Result status codes
    localparam logic [1:0] ST_HIT   = 2'd0;
    localparam logic [1:0] ST_MISS  = 2'd1;
    localparam logic [1:0] ST_DEGEN = 2'd2;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] rx;
        logic signed [CW-1:0] ry;
        logic                 closer;
    } side_t;

    typedef struct packed {
        logic signed [CW-1:0] a;
        logic signed [CW-1:0] b;
        logic signed [CW-1:0] c;
        logic [RW-1:0]        r;
        side_t                side;
    } item_t;

    typedef struct packed {
        logic signed [CW-1:0] a;
        logic signed [CW-1:0] b;
        logic signed [MW-1:0] s;
        logic [DW-1:0]        d;
        logic [MW-1:0]        r2;
        side_t                side;
    } p1_t;

    typedef struct packed {
        logic signed [CW-1:0] a;
        logic signed [CW-1:0] b;
        logic [DW-1:0]        d;
        logic signed [NW-1:0] u;
        logic signed [NW-1:0] v;
        logic                 degen;
        logic                 miss;
        side_t                side;
    } mid_t;

    typedef struct packed {
        side_t side;
        logic  degen;
        logic  miss;
    } tail_t;

    typedef struct packed {
        logic signed [NW-1:0] n1x;
        logic signed [NW-1:0] n1y;
        logic signed [NW-1:0] n2x;
        logic signed [NW-1:0] n2y;
        logic [DW-1:0]        d;
        tail_t                tail;
    } p3_t;

    typedef struct packed {
        logic signed [CW-1:0] x1;
        logic signed [CW-1:0] y1;
        logic signed [CW-1:0] x2;
        logic signed [CW-1:0] y2;
        tail_t                tail;
    } p4_t;

endpackage

@@ rtl/core/lcp_if.sv @@
// Request and response channel interfaces of the touch point block.
interface lcp_req_if;
    import lcp_pkg::*;

    logic                 valid;
    logic                 ready;
    logic signed [CW-1:0] line_a;
    logic signed [CW-1:0] line_b;
    logic signed [CW-1:0] line_c;
    logic signed [CW-1:0] center_x;
    logic signed [CW-1:0] center_y;
    logic [RW-1:0]        circle_radius;
    logic signed [CW-1:0] ref_x;
    logic signed [CW-1:0] ref_y;
    logic                 prefer_closer;

    modport source (
        output valid, line_a, line_b, line_c, center_x, center_y,
               circle_radius, ref_x, ref_y, prefer_closer,
        input  ready
    );
    modport sink (
        input  valid, line_a, line_b, line_c, center_x, center_y,
               circle_radius, ref_x, ref_y, prefer_closer,
        output ready
    );
endinterface

interface lcp_rsp_if;
    import lcp_pkg::*;

    logic                 valid;
    logic                 ready;
    logic signed [CW-1:0] point_x;
    logic signed [CW-1:0] point_y;
    logic [1:0]           status;

    modport source (
        output valid, point_x, point_y, status,
        input  ready
    );
    modport sink (
        input  valid, point_x, point_y, status,
        output ready
    );
endinterface

@@ rtl/core/lcp_mul.sv @@
// Five-stage signed multiplier built from 22x22 partial products.
module lcp_mul (
    input  logic                          clk,
    input  logic                          en,
    input  logic signed [lcp_pkg::MW-1:0] a,
    input  logic signed [lcp_pkg::MW-1:0] b,
    output logic signed [lcp_pkg::PW-1:0] p
);
    import lcp_pkg::*;

    localparam int PPW  = 2 * CH;
    localparam int ROWW = PPW + (NCH - 1) * CH + 2;

    logic [MW-1:0]   ma_reg, mb_reg;
    logic            neg_reg [LAT_MUL-1];
    logic [PPW-1:0]  pp_reg [NCH][NCH];
    logic [ROWW-1:0] row_reg [NCH];
    logic [PW-1:0]   tot_reg;
    logic [ROWW-1:0] row_next [NCH];
    logic [PW-1:0]   tot_next;

    // Row sums and final sum of the partial products
    always_comb
    begin
        for (int i = 0; i < NCH; i++)
        begin
            row_next[i] = '0;
            for (int j = 0; j < NCH; j++)
            begin
                row_next[i] = row_next[i] + (ROWW'(pp_reg[i][j]) << (j * CH));
            end
        end
        tot_next = '0;
        for (int i = 0; i < NCH; i++)
        begin
            tot_next = tot_next + (PW'(row_reg[i]) << (i * CH));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // stage 1: magnitudes and product sign
            ma_reg     <= a[MW-1] ? MW'(-a) : MW'(a);
            mb_reg     <= b[MW-1] ? MW'(-b) : MW'(b);
            neg_reg[0] <= a[MW-1] ^ b[MW-1];
            for (int k = 1; k < LAT_MUL - 1; k++)
            begin
                neg_reg[k] <= neg_reg[k-1];
            end
            // stage 2: partial products
            for (int i = 0; i < NCH; i++)
            begin
                for (int j = 0; j < NCH; j++)
                begin
                    pp_reg[i][j] <= PPW'(ma_reg[i*CH +: CH]) * PPW'(mb_reg[j*CH +: CH]);
                end
            end
            // stages 3 and 4: row sums, total
            row_reg <= row_next;
            tot_reg <= tot_next;
            // stage 5: restore sign
            p <= neg_reg[LAT_MUL-2] ? $signed(-tot_reg) : $signed(tot_reg);
        end
    end

endmodule

@@ rtl/core/lcp_sqrt.sv @@
// Pipelined integer square root, one root bit per stage.
module lcp_sqrt (
    input  logic                       clk,
    input  logic                       en,
    input  logic [lcp_pkg::EW-1:0]     e,
    output logic [lcp_pkg::RTW-1:0]    root
);
    import lcp_pkg::*;

    typedef struct packed {
        logic [EW-1:0]     e;
        logic [SQREMW-1:0] rem;
        logic [RTW-1:0]    root;
    } sq_t;

    sq_t st_reg [RTW];
    sq_t st0;

    // One restoring step: bring down two radicand bits, try root*4+1
    function automatic sq_t sq_step(sq_t s);
        sq_t               o;
        logic [SQREMW+1:0] cur;
        logic [SQREMW+1:0] trial;
        cur   = {s.rem, s.e[EW-1 -: 2]};
        trial = (SQREMW+2)'({s.root, 2'b01});
        o.e   = s.e << 2;
        if (cur >= trial)
        begin
            o.rem  = SQREMW'(cur - trial);
            o.root = {s.root[RTW-2:0], 1'b1};
        end
        else
        begin
            o.rem  = SQREMW'(cur);
            o.root = {s.root[RTW-2:0], 1'b0};
        end
        return o;
    endfunction

    assign st0  = '{e: e, rem: '0, root: '0};
    assign root = st_reg[RTW-1].root;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_reg[0] <= sq_step(st0);
            for (int k = 1; k < RTW; k++)
            begin
                st_reg[k] <= sq_step(st_reg[k-1]);
            end
        end
    end

endmodule

@@ rtl/core/lcp_div.sv @@
// Pipelined signed divider: rounds half away from zero, holds magnitude at 2^(QB-1).
module lcp_div (
    input  logic                          clk,
    input  logic                          en,
    input  logic signed [lcp_pkg::NW-1:0] n,
    input  logic [lcp_pkg::DW-1:0]        d,
    output logic signed [lcp_pkg::QW-1:0] q
);
    import lcp_pkg::*;

    localparam logic [QB:0] QLIM = (QB+1)'(1) << (QB - 1);

    typedef struct packed {
        logic [DW-1:0] rem;
        logic [QB-1:0] low;
        logic [QB-1:0] q;
        logic [DW-1:0] d;
        logic          big;
        logic          neg;
    } dv_t;

    logic [NW-1:0] m_reg;
    logic [DW-1:0] d_reg;
    logic          neg_reg;
    dv_t           init_reg;
    dv_t           st_reg [QB];
    logic [QB-1:0] qm_reg;
    logic          qneg_reg;
    dv_t           init_next;
    logic          rnd;
    logic [QB:0]   q2;

    // One restoring step
    function automatic dv_t dv_step(dv_t s);
        dv_t       o;
        logic [DW:0] cur;
        o   = s;
        cur = {s.rem, s.low[QB-1]};
        o.low = s.low << 1;
        if (cur >= {1'b0, s.d})
        begin
            o.rem = DW'(cur - {1'b0, s.d});
            o.q   = {s.q[QB-2:0], 1'b1};
        end
        else
        begin
            o.rem = DW'(cur);
            o.q   = {s.q[QB-2:0], 1'b0};
        end
        return o;
    endfunction

    // High part at or above the divisor means the quotient is past the limit
    always_comb
    begin
        init_next.rem = DW'(m_reg[NW-1:QB]);
        init_next.low = m_reg[QB-1:0];
        init_next.q   = '0;
        init_next.d   = d_reg;
        init_next.big = DW'(m_reg[NW-1:QB]) >= d_reg;
        init_next.neg = neg_reg;
    end

    // Round half away from zero from the final remainder
    assign rnd = {st_reg[QB-1].rem, 1'b0} >= {1'b0, st_reg[QB-1].d};
    assign q2  = (QB+1)'(st_reg[QB-1].q) + (QB+1)'(rnd);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_reg    <= n[NW-1] ? NW'(-n) : NW'(n);
            d_reg    <= d;
            neg_reg  <= n[NW-1];
            init_reg <= init_next;
            st_reg[0] <= dv_step(init_reg);
            for (int k = 1; k < QB; k++)
            begin
                st_reg[k] <= dv_step(st_reg[k-1]);
            end
            qm_reg   <= (st_reg[QB-1].big || q2 > QLIM) ? QLIM[QB-1:0] : q2[QB-1:0];
            qneg_reg <= st_reg[QB-1].neg;
            q        <= qneg_reg ? -$signed({1'b0, qm_reg}) : $signed({1'b0, qm_reg});
        end
    end

endmodule

@@ rtl/core/line_circle_touch_point.sv @@
// Top level of the line and circle touch point pipeline.
//
// Takes one query per cycle while the response side keeps up and returns one result per
// query, in order. The depth comes from the 63-stage square root and the 45-stage
// dividers that scale both crossings by A*A+B*B, plus four five-stage multiplier banks.
// A stalled response only holds the pipeline once its last stage is full; bubbles ahead
// of it keep draining, so the request side stays ready.
module line_circle_touch_point (
    input  logic      clk,
    input  logic      rst_n,
    lcp_req_if.sink   req,
    lcp_rsp_if.source rsp
);
    import lcp_pkg::*;

    logic en;
    logic vld_reg [LAT_TOTAL];

    item_t in0_reg;
    item_t dly0_reg [LAT_MUL];
    p1_t   p1_reg;
    p1_t   dly1_reg [LAT_MUL];
    mid_t  mid_reg;
    logic [EW-1:0] e_reg;
    mid_t  dly2_reg [LAT_SQRT];
    mid_t  dly3_reg [LAT_MUL];
    p3_t   p3_reg;
    tail_t dly4_reg [LAT_DIV];
    p4_t   p4_reg;
    p4_t   dly5_reg [LAT_MUL];
    p4_t   p5_reg;
    logic [DISTW-1:0] dist1_reg, dist2_reg;

    logic                 out_vld_reg;
    logic signed [CW-1:0] out_x_reg, out_y_reg;
    logic [1:0]           out_st_reg;

    logic signed [PW-1:0] aa_p, bb_p, ax_p, by_p, rr_p;
    logic signed [PW-1:0] rd_p, ss_p, as_p, bs_p;
    logic signed [PW-1:0] bw_p, aw_p;
    logic signed [PW-1:0] s1x_p, s1y_p, s2x_p, s2y_p;
    logic [RTW-1:0]       root;
    logic signed [QW-1:0] q1x, q1y, q2x, q2y;

    logic signed [PW-1:0] e_full;
    p1_t                  p1_next;
    mid_t                 mid_next;
    p3_t                  p3_next;
    p4_t                  p4_next;
    logic signed [CW:0]   dx1, dy1, dx2, dy2;
    logic                 first_nearer;

    // Saturating add of a quotient to a centre coordinate
    function automatic logic signed [CW-1:0] sat_add(logic signed [CW-1:0] x,
                                                     logic signed [QW-1:0] qv);
        logic signed [QW:0] sum;
        logic               ovf;
        sum = (QW+1)'(x) + (QW+1)'(qv);
        ovf = sum[QW:CW-1] != {(QW-CW+2){sum[QW]}};
        if (ovf)
        begin
            return sum[QW] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
        end
        return sum[CW-1:0];
    endfunction

    // Pipeline advances unless a full last stage meets a held response
    assign en        = !vld_reg[LAT_TOTAL-1] || !out_vld_reg || rsp.ready;
    assign req.ready = en;

    assign rsp.valid   = out_vld_reg;
    assign rsp.point_x = out_x_reg;
    assign rsp.point_y = out_y_reg;
    assign rsp.status  = out_st_reg;

    // Products A*A, B*B, A*x, B*y, r*r
    lcp_mul u_mul_aa (.clk, .en, .a(MW'(in0_reg.a)), .b(MW'(in0_reg.a)), .p(aa_p));
    lcp_mul u_mul_bb (.clk, .en, .a(MW'(in0_reg.b)), .b(MW'(in0_reg.b)), .p(bb_p));
    lcp_mul u_mul_ax (.clk, .en, .a(MW'(in0_reg.a)), .b(MW'(in0_reg.side.x)), .p(ax_p));
    lcp_mul u_mul_by (.clk, .en, .a(MW'(in0_reg.b)), .b(MW'(in0_reg.side.y)), .p(by_p));
    lcp_mul u_mul_rr (.clk, .en, .a($signed(MW'(in0_reg.r))), .b($signed(MW'(in0_reg.r))),
                      .p(rr_p));

    // Line value S and norm D
    always_comb
    begin
        p1_next.a    = dly0_reg[LAT_MUL-1].a;
        p1_next.b    = dly0_reg[LAT_MUL-1].b;
        p1_next.s    = ax_p[MW-1:0] + by_p[MW-1:0]
                     + (MW'(dly0_reg[LAT_MUL-1].c) <<< FRAC_BITS);
        p1_next.d    = aa_p[DW-1:0] + bb_p[DW-1:0];
        p1_next.r2   = rr_p[MW-1:0];
        p1_next.side = dly0_reg[LAT_MUL-1].side;
    end

    // Products r*r*D, S*S, A*S, B*S
    lcp_mul u_mul_rd (.clk, .en, .a($signed(p1_reg.r2)), .b($signed(MW'(p1_reg.d))), .p(rd_p));
    lcp_mul u_mul_ss (.clk, .en, .a(p1_reg.s), .b(p1_reg.s), .p(ss_p));
    lcp_mul u_mul_as (.clk, .en, .a(MW'(p1_reg.a)), .b(p1_reg.s), .p(as_p));
    lcp_mul u_mul_bs (.clk, .en, .a(MW'(p1_reg.b)), .b(p1_reg.s), .p(bs_p));

    // Discriminant, miss flag and degenerate flag
    assign e_full = rd_p - ss_p;
    always_comb
    begin
        mid_next.a     = dly1_reg[LAT_MUL-1].a;
        mid_next.b     = dly1_reg[LAT_MUL-1].b;
        mid_next.d     = dly1_reg[LAT_MUL-1].d;
        mid_next.u     = as_p[NW-1:0];
        mid_next.v     = bs_p[NW-1:0];
        mid_next.degen = dly1_reg[LAT_MUL-1].d == '0;
        mid_next.miss  = e_full[PW-1];
        mid_next.side  = dly1_reg[LAT_MUL-1].side;
    end

    lcp_sqrt u_sqrt (.clk, .en, .e(e_reg), .root);

    // Half-chord terms B*W and A*W
    lcp_mul u_mul_bw (.clk, .en, .a(MW'(dly2_reg[LAT_SQRT-1].b)), .b($signed(MW'(root))),
                      .p(bw_p));
    lcp_mul u_mul_aw (.clk, .en, .a(MW'(dly2_reg[LAT_SQRT-1].a)), .b($signed(MW'(root))),
                      .p(aw_p));

    // Numerators of both crossings
    always_comb
    begin
        p3_next.n1x  = bw_p[NW-1:0] - dly3_reg[LAT_MUL-1].u;
        p3_next.n1y  = -dly3_reg[LAT_MUL-1].v - aw_p[NW-1:0];
        p3_next.n2x  = -bw_p[NW-1:0] - dly3_reg[LAT_MUL-1].u;
        p3_next.n2y  = aw_p[NW-1:0] - dly3_reg[LAT_MUL-1].v;
        p3_next.d    = dly3_reg[LAT_MUL-1].d;
        p3_next.tail = '{side:  dly3_reg[LAT_MUL-1].side,
                         degen: dly3_reg[LAT_MUL-1].degen,
                         miss:  dly3_reg[LAT_MUL-1].miss};
    end

    lcp_div u_div_1x (.clk, .en, .n(p3_reg.n1x), .d(p3_reg.d), .q(q1x));
    lcp_div u_div_1y (.clk, .en, .n(p3_reg.n1y), .d(p3_reg.d), .q(q1y));
    lcp_div u_div_2x (.clk, .en, .n(p3_reg.n2x), .d(p3_reg.d), .q(q2x));
    lcp_div u_div_2y (.clk, .en, .n(p3_reg.n2y), .d(p3_reg.d), .q(q2y));

    // Saturated crossing coordinates
    always_comb
    begin
        p4_next.tail = dly4_reg[LAT_DIV-1];
        p4_next.x1   = sat_add(dly4_reg[LAT_DIV-1].side.x, q1x);
        p4_next.y1   = sat_add(dly4_reg[LAT_DIV-1].side.y, q1y);
        p4_next.x2   = sat_add(dly4_reg[LAT_DIV-1].side.x, q2x);
        p4_next.y2   = sat_add(dly4_reg[LAT_DIV-1].side.y, q2y);
    end

    // Offsets to the reference point and their squares
    assign dx1 = (CW+1)'(p4_reg.x1) - (CW+1)'(p4_reg.tail.side.rx);
    assign dy1 = (CW+1)'(p4_reg.y1) - (CW+1)'(p4_reg.tail.side.ry);
    assign dx2 = (CW+1)'(p4_reg.x2) - (CW+1)'(p4_reg.tail.side.rx);
    assign dy2 = (CW+1)'(p4_reg.y2) - (CW+1)'(p4_reg.tail.side.ry);

    lcp_mul u_mul_s1x (.clk, .en, .a(MW'(dx1)), .b(MW'(dx1)), .p(s1x_p));
    lcp_mul u_mul_s1y (.clk, .en, .a(MW'(dy1)), .b(MW'(dy1)), .p(s1y_p));
    lcp_mul u_mul_s2x (.clk, .en, .a(MW'(dx2)), .b(MW'(dx2)), .p(s2x_p));
    lcp_mul u_mul_s2y (.clk, .en, .a(MW'(dy2)), .b(MW'(dy2)), .p(s2y_p));

    assign first_nearer = dist1_reg < dist2_reg;

    // Datapath stage registers and delay lines
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            in0_reg.a           <= req.line_a;
            in0_reg.b           <= req.line_b;
            in0_reg.c           <= req.line_c;
            in0_reg.r           <= req.circle_radius;
            in0_reg.side.x      <= req.center_x;
            in0_reg.side.y      <= req.center_y;
            in0_reg.side.rx     <= req.ref_x;
            in0_reg.side.ry     <= req.ref_y;
            in0_reg.side.closer <= req.prefer_closer;

            dly0_reg[0] <= in0_reg;
            dly1_reg[0] <= p1_reg;
            dly3_reg[0] <= dly2_reg[LAT_SQRT-1];
            dly5_reg[0] <= p4_reg;
            for (int k = 1; k < LAT_MUL; k++)
            begin
                dly0_reg[k] <= dly0_reg[k-1];
                dly1_reg[k] <= dly1_reg[k-1];
                dly3_reg[k] <= dly3_reg[k-1];
                dly5_reg[k] <= dly5_reg[k-1];
            end
            dly2_reg[0] <= mid_reg;
            for (int k = 1; k < LAT_SQRT; k++)
            begin
                dly2_reg[k] <= dly2_reg[k-1];
            end
            dly4_reg[0] <= p3_reg.tail;
            for (int k = 1; k < LAT_DIV; k++)
            begin
                dly4_reg[k] <= dly4_reg[k-1];
            end

            p1_reg    <= p1_next;
            mid_reg   <= mid_next;
            e_reg     <= e_full[PW-1] ? '0 : e_full[EW-1:0];
            p3_reg    <= p3_next;
            p4_reg    <= p4_next;
            p5_reg    <= dly5_reg[LAT_MUL-1];
            dist1_reg <= s1x_p[DISTW-1:0] + s1y_p[DISTW-1:0];
            dist2_reg <= s2x_p[DISTW-1:0] + s2y_p[DISTW-1:0];
        end
    end

    // Valid line
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < LAT_TOTAL; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= req.valid;
            for (int k = 1; k < LAT_TOTAL; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    // Output register: pick a crossing, or report the foot or a degenerate line
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (!out_vld_reg || rsp.ready)
        begin
            out_vld_reg <= vld_reg[LAT_TOTAL-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_vld_reg || rsp.ready)
        begin
            if (p5_reg.tail.degen)
            begin
                out_x_reg  <= '0;
                out_y_reg  <= '0;
                out_st_reg <= ST_DEGEN;
            end
            else if (p5_reg.tail.miss)
            begin
                out_x_reg  <= p5_reg.x1;
                out_y_reg  <= p5_reg.y1;
                out_st_reg <= ST_MISS;
            end
            else if (p5_reg.tail.side.closer == first_nearer)
            begin
                out_x_reg  <= p5_reg.x1;
                out_y_reg  <= p5_reg.y1;
                out_st_reg <= ST_HIT;
            end
            else
            begin
                out_x_reg  <= p5_reg.x2;
                out_y_reg  <= p5_reg.y2;
                out_st_reg <= ST_HIT;
            end
        end
    end

    // A degenerate line always reports the origin
    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.status == ST_DEGEN |-> rsp.point_x == '0 && rsp.point_y == '0)
        else $error("degenerate result with nonzero point");

    // A full last stage facing a held response freezes the request side
    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.ready && vld_reg[LAT_TOTAL-1] |-> !req.ready)
        else $error("pipeline advanced into a held response");

    // An accepted request enters the valid line
    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> vld_reg[0])
        else $error("accepted request lost at pipeline entry");

    // A response appears only from a valid last stage
    a_rsp_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp.valid) |-> $past(vld_reg[LAT_TOTAL-1]))
        else $error("response without a finished item");

endmodule
